@@ design/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
package u8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplChar = 21'd65533;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               malformed;
    logic               run_last;
  } u8d_result_t;

  // Decoder step outcome: up to two results plus the next sequence state.
  typedef struct packed {
    u8d_result_t [1:0]  res;
    logic [1:0]         count;
    logic [CpWidth-1:0] partial;
    logic [1:0]         remaining;
  } u8d_step_t;

endpackage

@@ design/u8d_decode.sv @@
// Combinational decode of one byte against the open sequence state.
// Depends on u8d_pkg for the step and result types.
module u8d_decode import u8d_pkg::*; (
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_data_i,
  input  logic [CpWidth-1:0] partial_i,
  input  logic [1:0]         remaining_i,
  output u8d_step_t          step_o
);

  logic               lead_emit;
  logic               lead_bad;
  logic [CpWidth-1:0] lead_cp;
  logic [CpWidth-1:0] lead_pv;
  logic [1:0]         lead_rem;
  logic               is_cont;

  assign is_cont = (data_byte_i[7:6] == 2'b10);

  // Lead byte classification, always computed from the current byte
  always_comb begin
    lead_emit = 1'b0;
    lead_bad  = 1'b0;
    lead_cp   = '0;
    lead_pv   = '0;
    lead_rem  = 2'd0;
    unique if (data_byte_i[7] == 1'b0) begin
      lead_emit = 1'b1;
      lead_cp   = {13'b0, data_byte_i};
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_pv  = {10'b0, data_byte_i[4:0], 6'b0};
      lead_rem = 2'd1;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_pv  = {5'b0, data_byte_i[3:0], 12'b0};
      lead_rem = 2'd2;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_pv  = {data_byte_i[2:0], 18'b0};
      lead_rem = 2'd3;
    end else begin
      lead_emit = 1'b1;
      lead_bad  = 1'b1;
      lead_cp   = ReplChar;
    end
  end

  always_comb begin
    step_o           = '0;
    step_o.partial   = partial_i;
    step_o.remaining = remaining_i;
    if (remaining_i == 2'd0) begin
      if (lead_emit) begin
        step_o.res[0].code_point = lead_cp;
        step_o.res[0].malformed  = lead_bad;
        step_o.count             = 2'd1;
      end
      step_o.partial   = lead_pv;
      step_o.remaining = lead_rem;
    end else if (is_cont) begin
      unique case (remaining_i)
        2'd1:    step_o.partial = partial_i | {15'b0, data_byte_i[5:0]};
        2'd2:    step_o.partial = partial_i | {9'b0, data_byte_i[5:0], 6'b0};
        2'd3:    step_o.partial = partial_i | {3'b0, data_byte_i[5:0], 12'b0};
        default: step_o.partial = partial_i;
      endcase
      step_o.remaining = remaining_i - 2'd1;
      if (remaining_i == 2'd1) begin
        step_o.res[0].code_point = step_o.partial;
        step_o.count             = 2'd1;
        step_o.partial           = '0;
      end
    end else begin
      // Bad continuation: replace, then treat the byte as a fresh lead
      step_o.res[0].code_point = ReplChar;
      step_o.res[0].malformed  = 1'b1;
      step_o.count             = 2'd1;
      if (lead_emit) begin
        step_o.res[1].code_point = lead_cp;
        step_o.res[1].malformed  = lead_bad;
        step_o.count             = 2'd2;
      end
      step_o.partial   = lead_pv;
      step_o.remaining = lead_rem;
    end

    // Cut sequence at end of data
    if (end_of_data_i && (step_o.remaining != 2'd0)) begin
      step_o.res[step_o.count[0]].code_point = ReplChar;
      step_o.res[step_o.count[0]].malformed  = 1'b1;
      step_o.count     = step_o.count + 2'd1;
      step_o.remaining = 2'd0;
      step_o.partial   = '0;
    end

    step_o.res[0].run_last = (step_o.count == 2'd1);
    step_o.res[1].run_last = 1'b1;
  end

endmodule

@@ design/u8d_out_buf.sv @@
// Two-entry result register between the decoder and the output stream.
// Depends on u8d_pkg for the result and step types.
module u8d_out_buf import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  u8d_step_t   step_i,
  output logic        can_push_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output u8d_result_t out_res_o
);

  u8d_result_t slot0_q, slot0_d;
  u8d_result_t slot1_q, slot1_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_res_o   = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // Take a new item only when the buffer is empty or drains this cycle
  assign can_push_o  = (count_q == 2'd0) || ((count_q == 2'd1) && pop);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    count_d = count_q;
    if (push_i) begin
      slot0_d = step_i.res[0];
      slot1_d = step_i.res[1];
      count_d = step_i.count;
    end else if (pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

@@ design/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder: one byte per item in, code points out.
// Latency: the first result of a byte is presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output stream is ready; a byte
// that yields two results holds the input while the second result drains.
// Reset (rst_ni low, asynchronous): no sequence open, output buffer empty.
// Uses u8d_pkg, u8d_decode and u8d_out_buf.
module utf8_stream_decoder_core import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic        m_axis_tuser_o,   // [0] malformed
  output logic        m_axis_tlast_o    // run_last
);

  logic [CpWidth-1:0] partial_q;
  logic [1:0]         remaining_q;
  u8d_step_t          step;
  u8d_result_t        out_res;
  logic               can_push;
  logic               accept;

  assign s_axis_tready_o = can_push;
  assign accept          = s_axis_tvalid_i && can_push;

  u8d_decode u_decode (
    .data_byte_i   (s_axis_tdata_i),
    .end_of_data_i (s_axis_tlast_i),
    .partial_i     (partial_q),
    .remaining_i   (remaining_q),
    .step_o        (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      remaining_q <= 2'd0;
    end else if (accept) begin
      partial_q   <= step.partial;
      remaining_q <= step.remaining;
    end
  end

  u8d_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .step_i      (step),
    .can_push_o  (can_push),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = {3'b0, out_res.code_point};
  assign m_axis_tuser_o = out_res.malformed;
  assign m_axis_tlast_o = out_res.run_last;

endmodule
